[rtl/aik_pkg.sv]
// ---------------------------------------------------------------------------
// Arm inverse kinematics package
// Shared types, angle constants and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
package aik_pkg;

  // CORDIC input vector width and internal datapath widths.
  localparam int CIN_W = 34;
  localparam int NORM_W = 41;
  localparam int CX_W = 43;
  localparam int MAX_STEPS = 32;
  localparam int ISQ_STEPS = 32;

  typedef logic signed [CIN_W-1:0] cvec_t;
  typedef logic [31:0] bang_t;

  localparam bang_t HALF_TURN = 32'h8000_0000;
  localparam bang_t THREE_QUARTER_TURN = 32'hC000_0000;

  localparam logic signed [15:0] DEG64_PER_TURN = 16'sd23040;
  localparam logic signed [16:0] WRIST_OFFSET = -17'sd5760;
  localparam logic [14:0] LINK_RESET = 15'd1600;

  typedef enum logic [1:0] {
    REG_WAIST    = 2'd0,
    REG_SHOULDER = 2'd1,
    REG_ELBOW    = 2'd2,
    REG_WRIST    = 2'd3
  } reg_idx_t;

  // atan(2^-i) in binary angle units, 2^32 per turn.
  localparam bang_t ATAN_TAB [MAX_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

endpackage

[rtl/aik_cordic.sv]
// ---------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// Normalizes the vector in two stages, then runs one rotation per stage and
// returns the binary angle of the input vector.
// ---------------------------------------------------------------------------
module aik_cordic
  import aik_pkg::*;
#(
  parameter int STEPS = 16
) (
  input  logic  clk,
  input  cvec_t vec_x,
  input  cvec_t vec_y,
  output bang_t angle
);

  logic [CIN_W-1:0] ax, ay;
  logic [39:0] m_a, m_b;
  logic signed [NORM_W-1:0] xa, ya, xb, yb;
  logic zero_a, neg_a;

  logic [39:0] m1_r;
  logic signed [NORM_W-1:0] x1_r, y1_r;
  logic zero1_r, neg1_r;

  logic signed [CX_W-1:0] x_r [0:STEPS];
  logic signed [CX_W-1:0] y_r [0:STEPS];
  bang_t a_r [0:STEPS];
  logic zero_r [0:STEPS];
  logic neg_r [0:STEPS];
  bang_t a0_nxt;

  // First half of the normalizing shift: coarse steps of 32, 16 and 8.
  always_comb begin
    ax = vec_x[CIN_W-1] ? CIN_W'(-vec_x) : CIN_W'(vec_x);
    ay = vec_y[CIN_W-1] ? CIN_W'(-vec_y) : CIN_W'(vec_y);
    m_a = (ax > ay) ? 40'(ax) : 40'(ay);
    xa = NORM_W'(vec_x);
    ya = NORM_W'(vec_y);
    zero_a = (vec_y == '0);
    neg_a = vec_x[CIN_W-1];
    if (m_a < (40'd1 << 8)) begin
      m_a = m_a << 32;
      xa = xa <<< 32;
      ya = ya <<< 32;
    end
    if (m_a < (40'd1 << 24)) begin
      m_a = m_a << 16;
      xa = xa <<< 16;
      ya = ya <<< 16;
    end
    if (m_a < (40'd1 << 32)) begin
      m_a = m_a << 8;
      xa = xa <<< 8;
      ya = ya <<< 8;
    end
  end

  always_ff @(posedge clk) begin
    m1_r <= m_a;
    x1_r <= xa;
    y1_r <= ya;
    zero1_r <= zero_a;
    neg1_r <= neg_a;
  end

  // Fine steps of 4, 2 and 1, then fold the left half-plane onto the right.
  always_comb begin
    m_b = m1_r;
    xb = x1_r;
    yb = y1_r;
    a0_nxt = '0;
    if (m_b < (40'd1 << 36)) begin
      m_b = m_b << 4;
      xb = xb <<< 4;
      yb = yb <<< 4;
    end
    if (m_b < (40'd1 << 38)) begin
      m_b = m_b << 2;
      xb = xb <<< 2;
      yb = yb <<< 2;
    end
    if (m_b < (40'd1 << 39)) begin
      xb = xb <<< 1;
      yb = yb <<< 1;
    end
    if (xb[NORM_W-1]) begin
      xb = -xb;
      yb = -yb;
      a0_nxt = HALF_TURN;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0] <= CX_W'(xb);
    y_r[0] <= CX_W'(yb);
    a_r[0] <= a0_nxt;
    zero_r[0] <= zero1_r;
    neg_r[0] <= neg1_r;
  end

  for (genvar gi = 0; gi < STEPS; gi++) begin : g_step
    always_ff @(posedge clk) begin
      if (!y_r[gi][CX_W-1] && (y_r[gi] != '0)) begin
        x_r[gi+1] <= x_r[gi] + (y_r[gi] >>> gi);
        y_r[gi+1] <= y_r[gi] - (x_r[gi] >>> gi);
        a_r[gi+1] <= a_r[gi] + ATAN_TAB[gi];
      end else begin
        x_r[gi+1] <= x_r[gi] - (y_r[gi] >>> gi);
        y_r[gi+1] <= y_r[gi] + (x_r[gi] >>> gi);
        a_r[gi+1] <= a_r[gi] - ATAN_TAB[gi];
      end
      zero_r[gi+1] <= zero_r[gi];
      neg_r[gi+1] <= neg_r[gi];
    end
  end

  // A vector on the x axis has an exact angle of zero or a half turn.
  assign angle = zero_r[STEPS] ? (neg_r[STEPS] ? HALF_TURN : '0) : a_r[STEPS];

endmodule

[rtl/arm_inverse_kinematics.sv]
// ---------------------------------------------------------------------------
// Four-axis arm inverse kinematics
// Law-of-cosines solver: squares, two pipelined square roots, four pipelined
// CORDIC arctangents and a conversion to 1/64 degree.
// ---------------------------------------------------------------------------
// Throughput: one word per cycle; busy is never asserted. The depth is set by
// the 32 bit-pair stages of the square roots and one stage per CORDIC step.
// Reset clears the valid pipeline and loads every link length with 1600.
module arm_inverse_kinematics
  import aik_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_target_x,
  input  logic signed [15:0] in_target_y,
  input  logic signed [15:0] in_target_z,
  output logic               out_valid,
  output logic signed [14:0] out_base_angle,
  output logic signed [14:0] out_shoulder_angle,
  output logic signed [14:0] out_elbow_angle,
  output logic signed [15:0] out_wrist_angle,
  output logic               out_unreachable,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int LAT = 6 + ISQ_STEPS + 1 + 2 + CORDIC_STEPS + 3 + 1;
  localparam int URD = CORDIC_STEPS + 6;

  logic accept;
  logic [LAT-1:0] vld_r;

  logic [14:0] waist_r, shoulder_r, elbow_r, wrist_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waist_r <= LINK_RESET;
      shoulder_r <= LINK_RESET;
      elbow_r <= LINK_RESET;
      wrist_r <= LINK_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx_t'(paddr[3:2]))
        REG_WAIST:    waist_r <= pwdata[14:0];
        REG_SHOULDER: shoulder_r <= pwdata[14:0];
        REG_ELBOW:    elbow_r <= pwdata[14:0];
        REG_WRIST:    wrist_r <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_t'(paddr[3:2]))
      REG_WAIST:    prdata = {17'd0, waist_r};
      REG_SHOULDER: prdata = {17'd0, shoulder_r};
      REG_ELBOW:    prdata = {17'd0, elbow_r};
      REG_WRIST:    prdata = {17'd0, wrist_r};
      default:      prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign busy = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // Stage 1: height, the squares of x, y and of the shoulder and elbow lengths, and their product.
  logic signed [17:0] h1_nxt;
  logic signed [31:0] xx_full, yy_full;
  logic [29:0] ss_nxt, ee_nxt, se_nxt;
  logic signed [15:0] x1_r, y1_r;
  logic signed [17:0] h1_r;
  logic [30:0] xx1_r, yy1_r;
  logic [29:0] ss1_r, ee1_r, se1_r;

  always_comb begin
    h1_nxt = 18'(in_target_z) - $signed({3'b0, waist_r}) + $signed({3'b0, wrist_r});
    xx_full = in_target_x * in_target_x;
    yy_full = in_target_y * in_target_y;
    ss_nxt = shoulder_r * shoulder_r;
    ee_nxt = elbow_r * elbow_r;
    se_nxt = shoulder_r * elbow_r;
  end

  always_ff @(posedge clk) begin
    x1_r <= in_target_x;
    y1_r <= in_target_y;
    h1_r <= h1_nxt;
    xx1_r <= xx_full[30:0];
    yy1_r <= yy_full[30:0];
    ss1_r <= ss_nxt;
    ee1_r <= ee_nxt;
    se1_r <= se_nxt;
  end

  // Stage 2: reach squared, height squared, cosine denominator.
  logic signed [35:0] hh_full;
  logic [31:0] r2_2_r, hh2_r;
  logic [30:0] d2_r;
  logic [29:0] ss2_r, ee2_r;
  logic signed [15:0] x2_r, y2_r;
  logic signed [17:0] h2_r;

  assign hh_full = h1_r * h1_r;

  always_ff @(posedge clk) begin
    r2_2_r <= 32'(xx1_r) + 32'(yy1_r);
    hh2_r <= hh_full[31:0];
    d2_r <= {se1_r, 1'b0};
    ss2_r <= ss1_r;
    ee2_r <= ee1_r;
    x2_r <= x1_r;
    y2_r <= y1_r;
    h2_r <= h1_r;
  end

  // Stage 3: cosine numerator.
  logic signed [34:0] n3_r;
  logic [31:0] r2_3_r;
  logic [30:0] d3_r;
  logic [29:0] ss3_r;
  logic signed [15:0] x3_r, y3_r;
  logic signed [17:0] h3_r;

  always_ff @(posedge clk) begin
    n3_r <= $signed(35'(r2_2_r) + 35'(hh2_r) - 35'(ss2_r) - 35'(ee2_r));
    r2_3_r <= r2_2_r;
    d3_r <= d2_r;
    ss3_r <= ss2_r;
    x3_r <= x2_r;
    y3_r <= y2_r;
    h3_r <= h2_r;
  end

  // Stage 4: clamp the numerator into [-D, D].
  logic signed [34:0] d_ext, n3_neg;
  logic signed [31:0] n4_nxt;
  logic [30:0] nabs4_nxt;
  logic ur4_nxt;
  logic signed [31:0] n4_r;
  logic [30:0] nabs4_r, d4_r;
  logic [31:0] r2_4_r;
  logic [29:0] ss4_r;
  logic signed [15:0] x4_r, y4_r;
  logic signed [17:0] h4_r;
  logic ur4_r;

  always_comb begin
    d_ext = $signed({4'b0, d3_r});
    n3_neg = -n3_r;
    if (n3_r > d_ext) begin
      n4_nxt = $signed({1'b0, d3_r});
      nabs4_nxt = d3_r;
      ur4_nxt = 1'b1;
    end else if (n3_r < -d_ext) begin
      n4_nxt = -$signed({1'b0, d3_r});
      nabs4_nxt = d3_r;
      ur4_nxt = 1'b1;
    end else begin
      n4_nxt = 32'(n3_r);
      nabs4_nxt = n3_r[34] ? n3_neg[30:0] : n3_r[30:0];
      ur4_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    n4_r <= n4_nxt;
    nabs4_r <= nabs4_nxt;
    ur4_r <= ur4_nxt;
    d4_r <= d3_r;
    r2_4_r <= r2_3_r;
    ss4_r <= ss3_r;
    x4_r <= x3_r;
    y4_r <= y3_r;
    h4_r <= h3_r;
  end

  // Stage 5: D^2, N^2 and the second shoulder term's x component.
  logic [61:0] dd5_r, nn5_r;
  logic signed [CIN_W-1:0] t5_r;
  logic signed [31:0] n5_r;
  logic [31:0] r2_5_r;
  logic signed [15:0] x5_r, y5_r;
  logic signed [17:0] h5_r;
  logic ur5_r;

  always_ff @(posedge clk) begin
    dd5_r <= d4_r * d4_r;
    nn5_r <= nabs4_r * nabs4_r;
    t5_r <= $signed({3'b0, ss4_r, 1'b0}) + CIN_W'(n4_r);
    n5_r <= n4_r;
    r2_5_r <= r2_4_r;
    x5_r <= x4_r;
    y5_r <= y4_r;
    h5_r <= h4_r;
    ur5_r <= ur4_r;
  end

  // Stage 6 loads both square roots; then one result bit per stage.
  logic [63:0] qv_r [0:ISQ_STEPS];
  logic [63:0] qr_r [0:ISQ_STEPS];
  logic [63:0] lv_r [0:ISQ_STEPS];
  logic [63:0] lr_r [0:ISQ_STEPS];
  logic signed [31:0] ns_r [0:ISQ_STEPS];
  logic signed [CIN_W-1:0] ts_r [0:ISQ_STEPS];
  logic signed [15:0] xs_r [0:ISQ_STEPS];
  logic signed [15:0] ys_r [0:ISQ_STEPS];
  logic signed [17:0] hs_r [0:ISQ_STEPS];
  logic urs_r [0:ISQ_STEPS];

  always_ff @(posedge clk) begin
    qv_r[0] <= 64'(dd5_r - nn5_r);
    qr_r[0] <= '0;
    lv_r[0] <= 64'({r2_5_r, 16'd0});
    lr_r[0] <= '0;
    ns_r[0] <= n5_r;
    ts_r[0] <= t5_r;
    xs_r[0] <= x5_r;
    ys_r[0] <= y5_r;
    hs_r[0] <= h5_r;
    urs_r[0] <= ur5_r;
    for (int k = 0; k < ISQ_STEPS; k++) begin
      ns_r[k+1] <= ns_r[k];
      ts_r[k+1] <= ts_r[k];
      xs_r[k+1] <= xs_r[k];
      ys_r[k+1] <= ys_r[k];
      hs_r[k+1] <= hs_r[k];
      urs_r[k+1] <= urs_r[k];
    end
  end

  for (genvar gk = 0; gk < ISQ_STEPS; gk++) begin : g_isqrt
    localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * gk);
    logic [63:0] qsum, lsum;

    assign qsum = qr_r[gk] + SQ_BIT;
    assign lsum = lr_r[gk] + SQ_BIT;

    always_ff @(posedge clk) begin
      if (qv_r[gk] >= qsum) begin
        qv_r[gk+1] <= qv_r[gk] - qsum;
        qr_r[gk+1] <= (qr_r[gk] >> 1) + SQ_BIT;
      end else begin
        qv_r[gk+1] <= qv_r[gk];
        qr_r[gk+1] <= qr_r[gk] >> 1;
      end
      if (lv_r[gk] >= lsum) begin
        lv_r[gk+1] <= lv_r[gk] - lsum;
        lr_r[gk+1] <= (lr_r[gk] >> 1) + SQ_BIT;
      end else begin
        lv_r[gk+1] <= lv_r[gk];
        lr_r[gk+1] <= lr_r[gk] >> 1;
      end
    end
  end

  // Vectors for the four arctangents.
  logic [30:0] q_root;
  logic [23:0] l_root;
  cvec_t bx_r, by_r, a1x_r, a1y_r, ex_r, ey_r, a2x_r, a2y_r;
  logic [URD-1:0] urd_r;

  assign q_root = qr_r[ISQ_STEPS][30:0];
  assign l_root = lr_r[ISQ_STEPS][23:0];

  always_ff @(posedge clk) begin
    bx_r <= CIN_W'(xs_r[ISQ_STEPS]);
    by_r <= CIN_W'(ys_r[ISQ_STEPS]);
    a1x_r <= $signed({10'd0, l_root});
    a1y_r <= CIN_W'(hs_r[ISQ_STEPS]) <<< 8;
    ex_r <= CIN_W'(ns_r[ISQ_STEPS]);
    ey_r <= $signed({3'b0, q_root});
    a2x_r <= ts_r[ISQ_STEPS];
    a2y_r <= -$signed({3'b0, q_root});
    urd_r <= {urd_r[URD-2:0], urs_r[ISQ_STEPS]};
  end

  bang_t ang_base, ang_elb, ang_sh1, ang_sh2;

  aik_cordic #(.STEPS(CORDIC_STEPS)) u_base (
    .clk(clk), .vec_x(bx_r), .vec_y(by_r), .angle(ang_base)
  );

  aik_cordic #(.STEPS(CORDIC_STEPS)) u_elb (
    .clk(clk), .vec_x(ex_r), .vec_y(ey_r), .angle(ang_elb)
  );

  aik_cordic #(.STEPS(CORDIC_STEPS)) u_sh1 (
    .clk(clk), .vec_x(a1x_r), .vec_y(a1y_r), .angle(ang_sh1)
  );

  aik_cordic #(.STEPS(CORDIC_STEPS)) u_sh2 (
    .clk(clk), .vec_x(a2x_r), .vec_y(a2y_r), .angle(ang_sh2)
  );

  // Conversion 1: signed binary angles, elbow clamp, shoulder difference.
  bang_t ea_clamp, sa_diff;
  logic signed [32:0] base_a_r, elb_a_r, sh_a_r;

  always_comb begin
    if (ang_elb > THREE_QUARTER_TURN) begin
      ea_clamp = '0;
    end else if (ang_elb > HALF_TURN) begin
      ea_clamp = HALF_TURN;
    end else begin
      ea_clamp = ang_elb;
    end
    sa_diff = ang_sh1 - ang_sh2;
  end

  // A half turn stays positive; anything above it wraps to negative.
  always_ff @(posedge clk) begin
    base_a_r <= $signed({ang_base[31] & (|ang_base[30:0]), ang_base});
    elb_a_r <= $signed({1'b0, ea_clamp});
    sh_a_r <= $signed({sa_diff[31] & (|sa_diff[30:0]), sa_diff});
  end

  // Conversion 2: scale to 1/64 degree units times 2^32.
  logic signed [47:0] base_p_r, elb_p_r, sh_p_r;

  always_ff @(posedge clk) begin
    base_p_r <= base_a_r * DEG64_PER_TURN;
    elb_p_r <= elb_a_r * DEG64_PER_TURN;
    sh_p_r <= sh_a_r * DEG64_PER_TURN;
  end

  // Conversion 3: round half up and drop the fraction.
  logic signed [47:0] base_rnd, elb_rnd, sh_rnd;
  logic signed [15:0] base_d_r, elb_d_r, sh_d_r;

  always_comb begin
    base_rnd = base_p_r + (48'sd1 <<< 31);
    elb_rnd = elb_p_r + (48'sd1 <<< 31);
    sh_rnd = sh_p_r + (48'sd1 <<< 31);
  end

  always_ff @(posedge clk) begin
    base_d_r <= base_rnd[47:32];
    elb_d_r <= elb_rnd[47:32];
    sh_d_r <= sh_rnd[47:32];
  end

  // Output word.
  logic signed [15:0] elb_neg;
  logic signed [16:0] wrist_nxt;

  always_comb begin
    elb_neg = -elb_d_r;
    wrist_nxt = WRIST_OFFSET - 17'(sh_d_r) + 17'(elb_d_r);
  end

  always_ff @(posedge clk) begin
    out_base_angle <= base_d_r[14:0];
    out_shoulder_angle <= sh_d_r[14:0];
    out_elbow_angle <= elb_neg[14:0];
    out_wrist_angle <= wrist_nxt[15:0];
    out_unreachable <= urd_r[URD-1];
  end

  assign out_valid = vld_r[LAT-1];

  // An out-of-reach target puts the elbow exactly straight or fully folded.
  a_unreach_elbow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unreachable) |->
      (out_elbow_angle == 15'sd0 || out_elbow_angle == -15'sd11520))
    else $error("unreachable target with intermediate elbow angle");

  a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_elbow_angle[14] || out_elbow_angle == 15'sd0))
    else $error("elbow angle positive");

  a_origin_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(in_target_x, LAT) == 16'sd0 && $past(in_target_y, LAT) == 16'sd0)
      |-> out_base_angle == 15'sd0)
    else $error("nonzero base angle for a target on the base axis");

endmodule

[bench/ik_checker.sv]
// ----------------------------------------------------------------------------
// Arm inverse kinematics checker
// Watches the configuration port, the target channel and the joint-angle
// channel. For every accepted target it predicts the joint angles and queues
// them. Each output word is compared field by field with the oldest queued set.
// ----------------------------------------------------------------------------
module ik_checker
  import aik_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [15:0] in_target_x,
  input  logic signed [15:0] in_target_y,
  input  logic signed [15:0] in_target_z,
  input  logic               out_valid,
  input  logic signed [14:0] out_base_angle,
  input  logic signed [14:0] out_shoulder_angle,
  input  logic signed [14:0] out_elbow_angle,
  input  logic signed [15:0] out_wrist_angle,
  input  logic               out_unreachable,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 errors,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [14:0] base;
    logic signed [14:0] shoulder;
    logic signed [14:0] elbow;
    logic signed [15:0] wrist;
    logic               unreach;
  } joints_t;

  joints_t joint_q[$];
  longint link_len[4];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Vectoring CORDIC: binary angle of (x, y), 2^32 units per turn.
  function automatic bang_t vector_angle(longint x, longint y);
    bang_t ang;
    longint ax, ay, m, dx, dy;
    ang = '0;
    if (y == 0) return (x < 0) ? HALF_TURN : bang_t'(0);
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    m = (ax > ay) ? ax : ay;
    while (m < (64'sd1 <<< 39)) begin
      x = x * 2;
      y = y * 2;
      m = m * 2;
    end
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = HALF_TURN;
    end
    for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        ang = ang + ATAN_TAB[i];
      end else begin
        x = x - dx;
        y = y + dy;
        ang = ang - ATAN_TAB[i];
      end
    end
    return ang;
  endfunction

  function automatic longint centered(bang_t a);
    longint v;
    v = longint'({32'd0, a});
    if (a > HALF_TURN) v = v - (64'sd1 <<< 32);
    return v;
  endfunction

  // Round half up to 1/64 degree.
  function automatic longint to_deg64(longint a);
    longint unsigned v;
    v = a * 23040 + (64'sd1 <<< 31) + (64'sd23040 <<< 32);
    return longint'(v >> 32) - 23040;
  endfunction

  function automatic joints_t solve_joints(logic signed [15:0] tx, logic signed [15:0] ty,
                                           logic signed [15:0] tz);
    joints_t j;
    longint x, y, z, s, e, h, r2, d, n, q, lr, sh, el, wr, bs;
    bang_t a1, a2, ea;
    x = tx;
    y = ty;
    z = tz;
    s = link_len[REG_SHOULDER];
    e = link_len[REG_ELBOW];
    h = z - link_len[REG_WAIST] + link_len[REG_WRIST];
    r2 = x * x + y * y;
    d = 2 * s * e;
    n = r2 + h * h - s * s - e * e;
    j.unreach = 1'b0;
    if (n > d) begin
      n = d;
      j.unreach = 1'b1;
    end
    if (n < -d) begin
      n = -d;
      j.unreach = 1'b1;
    end
    q = longint'(int_sqrt(longint'(d * d - n * n)));
    bs = to_deg64(centered(vector_angle(x, y)));
    ea = vector_angle(n, q);
    if (ea > THREE_QUARTER_TURN) ea = '0;
    else if (ea > HALF_TURN) ea = HALF_TURN;
    el = -to_deg64(longint'({32'd0, ea}));
    lr = longint'(int_sqrt(longint'(r2) << 16));
    a1 = vector_angle(lr, h * 256);
    a2 = vector_angle(2 * s * s + n, -q);
    sh = to_deg64(centered(a1 - a2));
    wr = -5760 - sh - el;
    j.base = bs[14:0];
    j.shoulder = sh[14:0];
    j.elbow = el[14:0];
    j.wrist = wr[15:0];
    return j;
  endfunction

  always @(posedge clk) begin
    joints_t want;
    if (!rst_n) begin
      link_len = '{default: 64'sd1600};
      joint_q.delete();
      errors = 0;
    end else begin
      if (out_valid) begin
        if (joint_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected output word at %0t", $realtime);
        end else begin
          want = joint_q.pop_front();
          if (want.base !== out_base_angle || want.shoulder !== out_shoulder_angle ||
              want.elbow !== out_elbow_angle || want.wrist !== out_wrist_angle ||
              want.unreach !== out_unreachable) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                       want.base, want.shoulder, want.elbow, want.wrist, want.unreach,
                       out_base_angle, out_shoulder_angle, out_elbow_angle,
                       out_wrist_angle, out_unreachable);
          end
        end
      end
      if (start && !busy) joint_q.push_back(solve_joints(in_target_x, in_target_y, in_target_z));
      if (psel && penable && pwrite && pready)
        link_len[paddr[3:2]] = longint'({49'd0, pwdata[14:0]});
    end
    pending = joint_q.size();
  end

endmodule

[bench/tb_top.sv]
// ----------------------------------------------------------------------------
// Arm inverse kinematics testbench
// Drives directed and random targets under several link-length settings,
// with random idle cycles, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import aik_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 61;
  localparam int WATCHDOG_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_target_x = '0, in_target_y = '0, in_target_z = '0;
  logic out_valid;
  logic signed [14:0] out_base_angle, out_shoulder_angle, out_elbow_angle;
  logic signed [15:0] out_wrist_angle;
  logic out_unreachable;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int errors, pending;
  int idle_pct = 37;
  int quiet_cycles = 0;
  int links[4] = '{1600, 1600, 1600, 1600};

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  arm_inverse_kinematics dut (.*);
  ik_checker chk (.*);

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_link(reg_idx_t idx, int val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    links[idx] = val;
  endtask

  task automatic send_target(int x, int y, int z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_target_x <= x[15:0];
    in_target_y <= y[15:0];
    in_target_z <= z[15:0];
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic int clip16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int rand_in(int lim);
    return $urandom_range(2 * lim) - lim;
  endfunction

  // Mostly targets near the arm's reach, so the elbow solution is exercised;
  // the rest spans the full coordinate range.
  task automatic random_targets(int count);
    int reach, x, y, z, lift;
    reach = links[REG_SHOULDER] + links[REG_ELBOW];
    if (reach > 32767) reach = 32767;
    lift = links[REG_WAIST] - links[REG_WRIST];
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 6) begin
        x = rand_in(reach);
        y = rand_in(reach);
        z = clip16(rand_in(reach) + lift);
      end else begin
        x = $signed($urandom_range(16'hFFFF) - 32768);
        y = $signed($urandom_range(16'hFFFF) - 32768);
        z = $signed($urandom_range(16'hFFFF) - 32768);
      end
      send_target(x, y, z);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: origin, exact full stretch, folded arm, axes and extremes.
    send_target(0, 0, 0);
    send_target(0, 0, 500);
    send_target(3200, 0, 0);
    send_target(0, 3200, 0);
    send_target(-3200, 0, 0);
    send_target(-2000, 0, 300);
    send_target(0, -2000, -300);
    send_target(1500, 1500, 1000);
    send_target(-1500, 1500, -1000);
    send_target(-1500, -1500, 2000);
    send_target(32767, 32767, 32767);
    send_target(-32768, -32768, -32768);
    send_target(32767, -32768, 0);
    send_target(-32768, 32767, 32767);
    send_target(0, 0, 32767);
    send_target(0, 0, -32768);
    send_target(1, 0, 0);
    send_target(-1, -1, 1);
    send_target(0, 1, 3199);
    send_target(2262, 2262, 0);
    drain();

    idle_pct = 0;
    random_targets(220);
    idle_pct = 37;
    drain();

    write_link(REG_WAIST, 0);
    write_link(REG_WRIST, 32767);
    write_link(REG_SHOULDER, 32767);
    write_link(REG_ELBOW, 1);
    send_target(0, 0, -32768);
    random_targets(100);
    // Let the pipeline empty completely before continuing.
    drain();
    start <= 1'b0;
    random_targets(100);
    drain();

    write_link(REG_WAIST, 32767);
    write_link(REG_WRIST, 0);
    write_link(REG_SHOULDER, 1);
    write_link(REG_ELBOW, 32767);
    random_targets(200);
    drain();

    // Zero-length link: the cosine argument collapses.
    write_link(REG_WAIST, 100);
    write_link(REG_WRIST, 50);
    write_link(REG_SHOULDER, 0);
    write_link(REG_ELBOW, 2000);
    send_target(2000, 0, 50);
    send_target(0, 0, 0);
    random_targets(150);
    drain();

    write_link(REG_WAIST, $urandom_range(32767));
    write_link(REG_WRIST, $urandom_range(32767));
    write_link(REG_SHOULDER, $urandom_range(1, 32767));
    write_link(REG_ELBOW, $urandom_range(1, 32767));
    random_targets(200);
    drain();

    write_link(REG_WAIST, 1200);
    write_link(REG_WRIST, 400);
    write_link(REG_SHOULDER, 1800);
    write_link(REG_ELBOW, 1500);
    random_targets(457);
    drain();

    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

[sim.f]
rtl/aik_pkg.sv
rtl/aik_cordic.sv
rtl/arm_inverse_kinematics.sv
bench/ik_checker.sv
bench/tb_top.sv
